### rtl/core/dep_pkg.sv
// Package: shared constants, tables and character helpers of the dimension parser.
package dep_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    // parse phases
    localparam logic [2:0] PH_START     = 3'd0;
    localparam logic [2:0] PH_AFTER_PLUS = 3'd1;
    localparam logic [2:0] PH_EXPECT    = 3'd2;
    localparam logic [2:0] PH_NUMBER    = 3'd3;
    localparam logic [2:0] PH_UNIT_ONE  = 3'd4;
    localparam logic [2:0] PH_UNIT_TAIL = 3'd5;
    localparam logic [2:0] PH_NAME      = 3'd6;

    // pending operators
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // default unit codes
    localparam logic [1:0] DU_INCH  = 2'd1;
    localparam logic [1:0] DU_POINT = 2'd2;

    localparam logic [13:0] F_INCH  = 14'd576;
    localparam logic [13:0] F_POINT = 14'd8;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam int FRAC_DIGITS = 6;

    typedef logic [15:0] t_frac_row [0:9];

    // floor((d << 16) / 10^k), row k-1
    localparam t_frac_row FRAC_TBL [0:FRAC_DIGITS-1] = '{
        '{16'd0, 16'd6553, 16'd13107, 16'd19660, 16'd26214,
          16'd32768, 16'd39321, 16'd45875, 16'd52428, 16'd58982},
        '{16'd0, 16'd655, 16'd1310, 16'd1966, 16'd2621,
          16'd3276, 16'd3932, 16'd4587, 16'd5242, 16'd5898},
        '{16'd0, 16'd65, 16'd131, 16'd196, 16'd262,
          16'd327, 16'd393, 16'd458, 16'd524, 16'd589},
        '{16'd0, 16'd6, 16'd13, 16'd19, 16'd26,
          16'd32, 16'd39, 16'd45, 16'd52, 16'd58},
        '{16'd0, 16'd0, 16'd1, 16'd1, 16'd2,
          16'd3, 16'd3, 16'd4, 16'd5, 16'd5},
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 16'd0}
    };

    typedef struct packed {
        logic        hit;
        logic [13:0] factor;
    } t_unit;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
    endfunction

    function automatic logic [1:0] oper_code(input logic [7:0] c);
        logic [1:0] r;
        case (c)
            CH_PLUS:  r = OP_ADD;
            CH_MINUS: r = OP_SUB;
            CH_STAR:  r = OP_MUL;
            default:  r = OP_DIV;
        endcase
        return r;
    endfunction

    function automatic t_unit unit_lookup(input logic [7:0] a, input logic [7:0] b);
        t_unit u;
        u.hit = 1'b1;
        case ({a, b})
            {8'h70, 8'h74}: u.factor = 14'd8;       // pt
            {8'h70, 8'h63}: u.factor = 14'd96;      // pc
            {CH_QUOTE, 8'h00},
            {8'h69, 8'h6E}: u.factor = 14'd576;     // in
            {CH_APOS, 8'h00},
            {8'h66, 8'h74}: u.factor = 14'd6912;    // ft
            {8'h63, 8'h62}: u.factor = 14'd10368;   // cb
            {8'h63, 8'h6D}: u.factor = 14'd227;     // cm
            {8'h6D, 8'h6D}: u.factor = 14'd23;      // mm
            {8'h6E, 8'h6F}: u.factor = 14'd1;       // no
            default: begin
                u.hit    = 1'b0;
                u.factor = 14'd0;
            end
        endcase
        return u;
    endfunction

endpackage

### rtl/core/dep_if.sv
// Interfaces: character input, result output and configuration write channels.
interface dep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       end_of_text;
    modport source (output valid, output text_char, output end_of_text, input ready);
    modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

interface dep_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic signed [15:0] whole_part;
    logic               sign_given;
    logic               ended_by_char;
    logic [7:0]         stop_char;
    logic               bad_syntax;
    logic               unknown_name;
    logic               divide_by_zero;
    modport source (output valid, output value, output whole_part, output sign_given,
                    output ended_by_char, output stop_char, output bad_syntax,
                    output unknown_name, output divide_by_zero, input ready);
    modport sink   (input valid, input value, input whole_part, input sign_given,
                    input ended_by_char, input stop_char, input bad_syntax,
                    input unknown_name, input divide_by_zero, output ready);
endinterface

interface dep_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/dimension_expression_parser_top.sv
// Top level: character-serial dimension expression parser with a shared mul/div unit.
//
// Channels: i_in takes one text character per beat (with an end-of-text mark),
// o_out gives one result beat per finished expression, i_cfg writes the
// default unit register (always ready; write only while idle).
// Each character is decoded in the beat it is taken; the parser takes no new
// character until it is back in idle. Characters that only advance the number
// pass through the dispatch step and back to idle. A character that closes an
// operand may run the shared iterative unit: unit scaling, * and / use it, and
// so does the default-unit scale at the end of a plain number. The iterative
// unit does one add/subtract per cycle.
// The result sits in an output register; the parser goes on taking
// characters while it waits. If a second result is ready before the first
// is taken, the parser holds in its emit step until o_out.ready.
// Reset clears the parse state and the output valid flag, and sets the default
// unit to none.
module dimension_expression_parser_top
    import dep_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dep_in_if.sink       i_in,
    dep_out_if.source    o_out,
    dep_cfg_if.sink      i_cfg
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    localparam logic [1:0] D_OPND = 2'd0;
    localparam logic [1:0] D_ACC  = 2'd1;
    localparam logic [1:0] D_EMIT = 2'd2;

    logic [2:0]   r_state, n_state;
    logic [1:0]   r_du, n_du;
    logic [2:0]   r_phase, n_phase;
    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_opnd, n_opnd;
    logic [1:0]   r_op, n_op;
    logic         r_neg, n_neg;
    logic         r_plain, n_plain;
    logic         r_sign, n_sign;
    logic         r_after, n_after;
    logic [2:0]   r_frac, n_frac;
    logic [7:0]   r_uf, n_uf;
    logic [7:0]   r_us, n_us;
    logic [2:0]   r_err, n_err;
    logic [7:0]   r_char, n_char;
    logic         r_eot, n_eot;
    logic         r_need_unit, n_need_unit;
    logic         r_need_fin, n_need_fin;
    logic         r_need_after, n_need_after;
    logic         r_stop, n_stop;
    logic         r_emit, n_emit;
    logic         r_by_char, n_by_char;
    // shared unit: multiplicand/quotient, multiplier/divisor, product/remainder
    logic [W-1:0] r_ua, n_ua;
    logic [W-1:0] r_ub, n_ub;
    logic [W-1:0] r_up, n_up;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [1:0]   r_dest, n_dest;
    logic         r_qneg, n_qneg;
    // output register
    logic         r_ovalid, n_ovalid;
    logic [31:0]  r_oval, n_oval;
    logic [15:0]  r_owhole, n_owhole;
    logic         r_osign, n_osign;
    logic         r_oby, n_oby;
    logic [7:0]   r_ochar, n_ochar;
    logic [2:0]   r_oerr, n_oerr;

    logic         accept;
    logic [W-1:0] x_op, d_op, mag_a, mag_d, prod, quo, q_signed;
    logic [W:0]   rem_sh;
    logic         qbit;
    logic [3:0]   digit;
    logic [W-1:0] round_sum;
    t_unit        unit;

    assign accept       = i_in.valid && i_in.ready;
    assign i_in.ready   = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    assign o_out.valid          = r_ovalid;
    assign o_out.value          = r_oval;
    assign o_out.whole_part     = r_owhole;
    assign o_out.sign_given     = r_osign;
    assign o_out.ended_by_char  = r_oby;
    assign o_out.stop_char      = r_ochar;
    assign o_out.bad_syntax     = r_oerr[0];
    assign o_out.unknown_name   = r_oerr[1];
    assign o_out.divide_by_zero = r_oerr[2];

    assign digit = 4'(i_in.text_char - CH_ZERO);

    // shared iterative unit datapath
    assign prod   = r_up + (r_ub[0] ? r_ua : '0);
    assign rem_sh = {r_up, r_ua[W-1]};
    assign qbit   = (rem_sh >= {1'b0, r_ub});
    assign quo    = {r_ua[W-2:0], qbit};
    assign q_signed = r_qneg ? (W'(0) - quo) : quo;

    assign x_op  = r_neg ? (W'(0) - r_opnd) : r_opnd;
    assign d_op  = W'($signed(x_op) >>> 8);
    assign mag_a = r_acc[W-1] ? (W'(0) - r_acc) : r_acc;
    assign mag_d = d_op[W-1] ? (W'(0) - d_op) : d_op;

    assign unit      = unit_lookup(r_uf, r_us);
    assign round_sum = r_acc + W'(32'h8000);

    always_comb begin
        n_state = r_state;   n_du = r_du;       n_phase = r_phase;
        n_acc = r_acc;       n_opnd = r_opnd;   n_op = r_op;
        n_neg = r_neg;       n_plain = r_plain; n_sign = r_sign;
        n_after = r_after;   n_frac = r_frac;   n_uf = r_uf;
        n_us = r_us;         n_err = r_err;     n_char = r_char;
        n_eot = r_eot;       n_need_unit = r_need_unit;
        n_need_fin = r_need_fin;  n_need_after = r_need_after;
        n_stop = r_stop;     n_emit = r_emit;   n_by_char = r_by_char;
        n_ua = r_ua;         n_ub = r_ub;       n_up = r_up;
        n_cnt = r_cnt;       n_dest = r_dest;   n_qneg = r_qneg;
        n_ovalid = r_ovalid && !o_out.ready;
        n_oval = r_oval;     n_owhole = r_owhole; n_osign = r_osign;
        n_oby = r_oby;       n_ochar = r_ochar; n_oerr = r_oerr;

        if (i_cfg.valid) begin
            n_du = i_cfg.data;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_char  = i_in.text_char;
                    n_eot   = i_in.end_of_text;
                    n_state = S_DISP;
                    // an unused phase code starts a fresh expression
                    if (r_phase > PH_NAME) begin
                        n_phase = PH_START; n_acc = '0; n_opnd = '0; n_op = OP_ADD;
                        n_neg = 1'b0; n_plain = 1'b1; n_sign = 1'b0; n_after = 1'b0;
                        n_frac = '0; n_uf = '0; n_us = '0; n_err = '0;
                    end
                    case (n_phase)
                        PH_START, PH_AFTER_PLUS, PH_EXPECT: begin
                            if (n_phase == PH_START && i_in.text_char == CH_PLUS) begin
                                n_sign  = 1'b1;
                                n_phase = PH_AFTER_PLUS;
                            end else if (n_phase != PH_EXPECT
                                         && i_in.text_char == CH_MINUS) begin
                                n_sign  = 1'b1;
                                n_neg   = 1'b1;
                                n_phase = PH_EXPECT;
                            end else if (is_digit(i_in.text_char)
                                         || i_in.text_char == CH_POINT) begin
                                n_frac  = '0;
                                n_phase = PH_NUMBER;
                                if (is_digit(i_in.text_char)) begin
                                    n_opnd  = W'(digit) << 16;
                                    n_after = 1'b0;
                                end else begin
                                    n_opnd  = '0;
                                    n_after = 1'b1;
                                end
                            end else if (is_alpha(i_in.text_char)) begin
                                n_opnd   = '0;
                                n_err[1] = 1'b1;
                                n_plain  = 1'b0;
                                n_phase  = PH_NAME;
                            end else begin
                                // missing operand
                                n_err[0]     = 1'b1;
                                n_opnd       = '0;
                                n_need_fin   = 1'b1;
                                n_need_after = 1'b1;
                            end
                        end
                        PH_NUMBER: begin
                            if (is_digit(i_in.text_char)) begin
                                if (r_after) begin
                                    if (r_frac < 3'(FRAC_DIGITS)) begin
                                        n_opnd = r_opnd + W'(FRAC_TBL[r_frac][digit]);
                                        n_frac = r_frac + 3'd1;
                                    end
                                end else begin
                                    n_opnd = (r_opnd << 3) + (r_opnd << 1)
                                             + (W'(digit) << 16);
                                end
                            end else if (i_in.text_char == CH_POINT) begin
                                n_after = 1'b1;
                            end else if (is_alpha(i_in.text_char)
                                         || i_in.text_char == CH_APOS
                                         || i_in.text_char == CH_QUOTE) begin
                                n_uf = i_in.text_char;
                                n_us = '0;
                                if (is_alpha(i_in.text_char)) begin
                                    n_phase = PH_UNIT_ONE;
                                end else begin
                                    n_need_unit = 1'b1;
                                    n_need_fin  = 1'b1;
                                    n_phase     = PH_UNIT_TAIL;
                                end
                            end else begin
                                n_need_fin   = 1'b1;
                                n_need_after = 1'b1;
                            end
                        end
                        PH_UNIT_ONE: begin
                            n_need_unit = 1'b1;
                            n_need_fin  = 1'b1;
                            if (is_alpha(i_in.text_char)) begin
                                n_us    = i_in.text_char;
                                n_phase = PH_UNIT_TAIL;
                            end else begin
                                n_need_after = 1'b1;
                            end
                        end
                        PH_UNIT_TAIL: begin
                            n_need_after = !is_alpha(i_in.text_char);
                        end
                        default: begin
                            if (!is_alpha(i_in.text_char) && !is_digit(i_in.text_char)) begin
                                n_need_fin   = 1'b1;
                                n_need_after = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_DISP: begin
                if (r_need_unit) begin
                    n_need_unit = 1'b0;
                    if (unit.hit) begin
                        n_plain = 1'b0;
                        n_ua    = r_opnd;
                        n_ub    = W'(unit.factor);
                        n_up    = '0;
                        n_cnt   = CW'(W);
                        n_dest  = D_OPND;
                        n_state = S_MUL;
                    end
                end else if (r_need_fin) begin
                    n_need_fin = 1'b0;
                    n_neg      = 1'b0;
                    n_opnd     = '0;
                    case (r_op)
                        OP_ADD: n_acc = r_acc + x_op;
                        OP_SUB: n_acc = r_acc - x_op;
                        OP_MUL: begin
                            n_ua    = W'($signed(r_acc) >>> 8);
                            n_ub    = d_op;
                            n_up    = '0;
                            n_cnt   = CW'(W);
                            n_dest  = D_ACC;
                            n_state = S_MUL;
                        end
                        default: begin
                            if (d_op == '0) begin
                                n_acc    = '0;
                                n_err[2] = 1'b1;
                            end else begin
                                n_ua    = mag_a;
                                n_ub    = mag_d;
                                n_up    = '0;
                                n_qneg  = r_acc[W-1] ^ d_op[W-1];
                                n_cnt   = CW'(W);
                                n_state = S_DIV;
                            end
                        end
                    endcase
                end else if (r_need_after) begin
                    n_need_after = 1'b0;
                    if (is_oper(r_char)) begin
                        n_op    = oper_code(r_char);
                        n_plain = 1'b0;
                        n_phase = PH_EXPECT;
                    end else begin
                        n_stop = 1'b1;
                    end
                end else if (r_stop) begin
                    // a stop character wins over its end-of-text mark
                    n_stop    = 1'b0;
                    n_eot     = 1'b0;
                    n_emit    = 1'b1;
                    n_by_char = 1'b1;
                end else if (r_eot) begin
                    n_eot     = 1'b0;
                    n_emit    = 1'b1;
                    n_by_char = 1'b0;
                    case (r_phase)
                        PH_NUMBER, PH_NAME: n_need_fin = 1'b1;
                        PH_UNIT_ONE: begin
                            n_need_unit = 1'b1;
                            n_need_fin  = 1'b1;
                        end
                        PH_UNIT_TAIL: ;
                        default: begin
                            n_err[0]   = 1'b1;
                            n_opnd     = '0;
                            n_need_fin = 1'b1;
                        end
                    endcase
                end else if (r_emit) begin
                    if (r_plain && (r_du == DU_INCH || r_du == DU_POINT)) begin
                        n_ua    = r_acc;
                        n_ub    = W'((r_du == DU_INCH) ? F_INCH : F_POINT);
                        n_up    = '0;
                        n_cnt   = CW'(W);
                        n_dest  = D_EMIT;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                n_up  = prod;
                n_ua  = r_ua << 1;
                n_ub  = r_ub >> 1;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = S_DISP;
                    case (r_dest)
                        D_OPND: n_opnd = prod;
                        D_EMIT: begin
                            n_acc   = prod;
                            n_plain = 1'b0;
                        end
                        default: n_acc = prod;
                    endcase
                end
            end
            S_DIV: begin
                n_up  = qbit ? W'(rem_sh - {1'b0, r_ub}) : rem_sh[W-1:0];
                n_ua  = quo;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_acc   = q_signed << 8;
                    n_state = S_DISP;
                end
            end
            S_EMIT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_oval   = r_acc[31:0];
                    n_owhole = round_sum[31:16];
                    n_osign  = r_sign;
                    n_oby    = r_by_char;
                    n_ochar  = r_by_char ? r_char : 8'd0;
                    n_oerr   = r_err;
                    // clear for the next expression
                    n_phase = PH_START; n_acc = '0; n_opnd = '0; n_op = OP_ADD;
                    n_neg = 1'b0; n_plain = 1'b1; n_sign = 1'b0; n_after = 1'b0;
                    n_frac = '0; n_uf = '0; n_us = '0; n_err = '0;
                    n_emit  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;   r_du <= '0;        r_phase <= PH_START;
            r_acc <= '0;         r_opnd <= '0;      r_op <= OP_ADD;
            r_neg <= 1'b0;       r_plain <= 1'b1;   r_sign <= 1'b0;
            r_after <= 1'b0;     r_frac <= '0;      r_uf <= '0;
            r_us <= '0;          r_err <= '0;       r_eot <= 1'b0;
            r_need_unit <= 1'b0; r_need_fin <= 1'b0; r_need_after <= 1'b0;
            r_stop <= 1'b0;      r_emit <= 1'b0;    r_ovalid <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;  r_du <= n_du;      r_phase <= n_phase;
            r_acc <= n_acc;      r_opnd <= n_opnd;  r_op <= n_op;
            r_neg <= n_neg;      r_plain <= n_plain; r_sign <= n_sign;
            r_after <= n_after;  r_frac <= n_frac;  r_uf <= n_uf;
            r_us <= n_us;        r_err <= n_err;    r_eot <= n_eot;
            r_need_unit <= n_need_unit; r_need_fin <= n_need_fin;
            r_need_after <= n_need_after;
            r_stop <= n_stop;    r_emit <= n_emit;  r_ovalid <= n_ovalid;
            r_cnt <= n_cnt;
        end
        r_char <= n_char;   r_by_char <= n_by_char;
        r_ua <= n_ua;       r_ub <= n_ub;       r_up <= n_up;
        r_dest <= n_dest;   r_qneg <= n_qneg;
        r_oval <= n_oval;   r_owhole <= n_owhole; r_osign <= n_osign;
        r_oby <= n_oby;     r_ochar <= n_ochar; r_oerr <= n_oerr;
    end

endmodule

### bench/dep_result_check.sv
// Result checker: snoops the channels, predicts each result and compares it.
`timescale 1ns / 1ps

module dep_result_check
    import dep_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    dep_in_if    in_ch,
    dep_out_if   out_ch,
    dep_cfg_if   cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [31:0] value;
        logic [15:0] whole_part;
        logic        sign_given;
        logic        ended_by_char;
        logic [7:0]  stop_char;
        logic        bad_syntax;
        logic        unknown_name;
        logic        divide_by_zero;
    } t_dim_result;

    t_dim_result expected_results [$];

    // parser image
    logic [1:0]  unit_sel;
    logic [2:0]  phase;
    logic [31:0] acc;
    logic [31:0] opnd;
    logic [1:0]  pend_op;
    logic        negate;
    logic        plain;
    logic        signed_start;
    logic        in_frac;
    int          frac_cnt;
    logic [7:0]  unit_a;
    logic [7:0]  unit_b;
    logic [2:0]  errs;

    function automatic logic [31:0] shr8(logic [31:0] x);
        return $signed(x) >>> 8;
    endfunction

    function automatic logic [31:0] quot_signed(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function void clear_expr();
        phase        = PH_START;
        acc          = '0;
        opnd         = '0;
        pend_op      = OP_ADD;
        negate       = 1'b0;
        plain        = 1'b1;
        signed_start = 1'b0;
        in_frac      = 1'b0;
        frac_cnt     = 0;
        unit_a       = '0;
        unit_b       = '0;
        errs         = '0;
    endfunction

    function void close_operand();
        logic [31:0] x;
        logic [31:0] d;
        x = opnd;
        if (negate) begin
            x = -x;
            negate = 1'b0;
        end
        case (pend_op)
            OP_ADD: acc = acc + x;
            OP_SUB: acc = acc - x;
            OP_MUL: acc = shr8(acc) * shr8(x);
            default: begin
                d = shr8(x);
                if (d == 0) begin
                    acc = '0;
                    errs[2] = 1'b1;
                end else begin
                    acc = quot_signed(acc, d) << 8;
                end
            end
        endcase
        opnd = '0;
    endfunction

    function void scale_by_unit();
        logic [31:0] f;
        case ({unit_a, unit_b})
            {"p", "t"}:                    f = 8;
            {"p", "c"}:                    f = 96;
            {CH_QUOTE, 8'h00}, {"i", "n"}: f = 576;
            {CH_APOS, 8'h00}, {"f", "t"}:  f = 6912;
            {"c", "b"}:                    f = 10368;
            {"c", "m"}:                    f = 227;
            {"m", "m"}:                    f = 23;
            {"n", "o"}:                    f = 1;
            default:                       f = 0;
        endcase
        if (f != 0) begin
            opnd  = opnd * f;
            plain = 1'b0;
        end
    endfunction

    function void number_char(logic [7:0] c);
        logic [31:0] d;
        logic [31:0] p10;
        d = {24'd0, c - CH_ZERO} << 16;
        if (is_digit(c)) begin
            if (in_frac) begin
                if (frac_cnt < 6) begin
                    p10 = 10 ** (frac_cnt + 1);
                    opnd = opnd + d / p10;
                    frac_cnt++;
                end
            end else begin
                opnd = opnd * 10 + d;
            end
        end else begin
            in_frac = 1'b1;
        end
    endfunction

    // returns 1 when c ends the expression
    function logic take_operator(logic [7:0] c);
        if (!is_oper(c)) return 1'b1;
        case (c)
            CH_PLUS:  pend_op = OP_ADD;
            CH_MINUS: pend_op = OP_SUB;
            CH_STAR:  pend_op = OP_MUL;
            default:  pend_op = OP_DIV;
        endcase
        plain = 1'b0;
        phase = PH_EXPECT;
        return 1'b0;
    endfunction

    function logic want_operand(logic [7:0] c);
        if (is_digit(c) || c == CH_POINT) begin
            opnd     = '0;
            in_frac  = 1'b0;
            frac_cnt = 0;
            number_char(c);
            phase = PH_NUMBER;
            return 1'b0;
        end
        if (is_alpha(c)) begin
            opnd    = '0;
            errs[1] = 1'b1;
            plain   = 1'b0;
            phase   = PH_NAME;
            return 1'b0;
        end
        errs[0] = 1'b1;
        opnd = '0;
        close_operand();
        return take_operator(c);
    endfunction

    function t_dim_result finish_expr(logic by_char, logic [7:0] c);
        t_dim_result r;
        logic [31:0] v;
        logic [31:0] rnd;
        v = acc;
        if (plain && unit_sel == DU_INCH) v = v * 576;
        else if (plain && unit_sel == DU_POINT) v = v * 8;
        rnd = $signed(v + 32'h8000) >>> 16;
        r.value          = v;
        r.whole_part     = rnd[15:0];
        r.sign_given     = signed_start;
        r.ended_by_char  = by_char;
        r.stop_char      = by_char ? c : 8'h00;
        r.bad_syntax     = errs[0];
        r.unknown_name   = errs[1];
        r.divide_by_zero = errs[2];
        clear_expr();
        return r;
    endfunction

    function logic parse_char(logic [7:0] c, logic eot, output t_dim_result r);
        logic stop;
        stop = 1'b0;
        case (phase)
            PH_AFTER_PLUS: begin
                if (c == CH_MINUS) begin
                    negate = 1'b1;
                    phase  = PH_EXPECT;
                end else begin
                    stop = want_operand(c);
                end
            end
            PH_EXPECT: stop = want_operand(c);
            PH_NUMBER: begin
                if (is_digit(c) || c == CH_POINT) begin
                    number_char(c);
                end else if (is_alpha(c) || c == CH_APOS || c == CH_QUOTE) begin
                    unit_a = c;
                    unit_b = 8'h00;
                    if (c == CH_APOS || c == CH_QUOTE) begin
                        scale_by_unit();
                        close_operand();
                        phase = PH_UNIT_TAIL;
                    end else begin
                        phase = PH_UNIT_ONE;
                    end
                end else begin
                    close_operand();
                    stop = take_operator(c);
                end
            end
            PH_UNIT_ONE: begin
                if (is_alpha(c)) begin
                    unit_b = c;
                    scale_by_unit();
                    close_operand();
                    phase = PH_UNIT_TAIL;
                end else begin
                    scale_by_unit();
                    close_operand();
                    stop = take_operator(c);
                end
            end
            PH_UNIT_TAIL: if (!is_alpha(c)) stop = take_operator(c);
            PH_NAME: begin
                if (!(is_alpha(c) || is_digit(c))) begin
                    close_operand();
                    stop = take_operator(c);
                end
            end
            default: begin
                // unused phase codes restart like a fresh expression
                if (phase != PH_START) clear_expr();
                if (c == CH_PLUS) begin
                    signed_start = 1'b1;
                    phase = PH_AFTER_PLUS;
                end else if (c == CH_MINUS) begin
                    signed_start = 1'b1;
                    negate = 1'b1;
                    phase = PH_EXPECT;
                end else begin
                    stop = want_operand(c);
                end
            end
        endcase
        if (stop) begin
            r = finish_expr(1'b1, c);
            return 1'b1;
        end
        if (eot) begin
            case (phase)
                PH_NUMBER, PH_NAME: close_operand();
                PH_UNIT_ONE: begin
                    scale_by_unit();
                    close_operand();
                end
                PH_UNIT_TAIL: ;
                default: begin
                    errs[0] = 1'b1;
                    opnd = '0;
                    close_operand();
                end
            endcase
            r = finish_expr(1'b0, 8'h00);
            return 1'b1;
        end
        r = '0;
        return 1'b0;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_dim_result pred;
        t_dim_result got;
        t_dim_result want;
        if (!i_rst_n) begin
            unit_sel = '0;
            clear_expr();
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) unit_sel = cfg_ch.data;
            if (in_ch.valid && in_ch.ready) begin
                if (parse_char(in_ch.text_char, in_ch.end_of_text, pred))
                    expected_results.push_back(pred);
            end
            if (out_ch.valid && out_ch.ready) begin
                got.value          = out_ch.value;
                got.whole_part     = out_ch.whole_part;
                got.sign_given     = out_ch.sign_given;
                got.ended_by_char  = out_ch.ended_by_char;
                got.stop_char      = out_ch.stop_char;
                got.bad_syntax     = out_ch.bad_syntax;
                got.unknown_name   = out_ch.unknown_name;
                got.divide_by_zero = out_ch.divide_by_zero;
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: result beat with nothing expected: %p", $realtime, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("%0t: mismatch\n  expected %p\n  actual   %p",
                                     $realtime, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### bench/dimension_expression_parser_top_test.sv
// Testbench top: clock, reset, character stimulus, register writes and verdict.
`timescale 1ns / 1ps

module dimension_expression_parser_top_test;
    import dep_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    logic calm;
    int   chars_sent;
    int   out_stall;

    dep_in_if  in_ch ();
    dep_out_if out_ch ();
    dep_cfg_if cfg_ch ();

    dimension_expression_parser_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    dep_result_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_stall = 0;
        end else if (out_stall > 0) begin
            out_ch.ready <= 1'b0;
            out_stall--;
        end else begin
            out_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0)
                out_stall = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3);
        end
    end

    task automatic send_char(input logic [7:0] c, input logic eot);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.text_char   <= c;
        in_ch.end_of_text <= eot;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_bytes(ref logic [7:0] q [$], input logic eot_last);
        for (int i = 0; i < q.size(); i++) send_char(q[i], eot_last && i == q.size() - 1);
    endtask

    task automatic settle_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_unit(input logic [1:0] u);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= u;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic add_number(ref logic [7:0] q [$]);
        int n;
        n = $urandom_range(0, 9) == 0 ? $urandom_range(4, 6) : $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0) q.push_back("0");
        for (int i = 0; i < n; i++) q.push_back(CH_ZERO + $urandom_range(0, 9));
        if (n == 0 || $urandom_range(0, 2) == 0) begin
            q.push_back(CH_POINT);
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) q.push_back(CH_ZERO + $urandom_range(0, 9));
        end
    endtask

    task automatic add_unit(ref logic [7:0] q [$]);
        string units [14] = '{"pt", "pc", "in", "\"", "'", "ft", "cb", "cm", "mm", "no",
                              "xy", "p", "\"q", "ptab"};
        string u;
        if ($urandom_range(0, 1) == 0) return;
        u = units[$urandom_range(0, 13)];
        for (int i = 0; i < u.len(); i++) q.push_back(u[i]);
    endtask

    task automatic add_name(ref logic [7:0] q [$]);
        int n;
        q.push_back($urandom_range(0, 1) ? 8'h61 + $urandom_range(0, 25)
                                          : 8'h41 + $urandom_range(0, 25));
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
            q.push_back($urandom_range(0, 1) ? 8'h61 + $urandom_range(0, 25)
                                              : CH_ZERO + $urandom_range(0, 9));
    endtask

    task automatic random_expression();
        logic [7:0] q [$];
        logic [7:0] stops [6] = '{8'h20, 8'h3B, 8'h29, 8'h2C, 8'h0A, 8'h00};
        int ops;
        int r;
        r = $urandom_range(0, 5);
        if (r == 0) q.push_back(CH_PLUS);
        else if (r == 1) q.push_back(CH_MINUS);
        else if (r == 2) begin
            q.push_back(CH_PLUS);
            q.push_back(CH_MINUS);
        end
        ops = $urandom_range(0, 3);
        for (int k = 0; k <= ops; k++) begin
            if (k > 0) begin
                case ($urandom_range(0, 3))
                    0: q.push_back(CH_PLUS);
                    1: q.push_back(CH_MINUS);
                    2: q.push_back(CH_STAR);
                    default: q.push_back(CH_SLASH);
                endcase
            end
            r = $urandom_range(0, 19);
            if (r == 0) add_name(q);
            else if (r == 1) q.push_back(stops[$urandom_range(0, 5)]);
            else begin
                add_number(q);
                add_unit(q);
            end
        end
        if ($urandom_range(0, 2) == 0) begin
            q.push_back(stops[$urandom_range(0, 5)]);
            send_bytes(q, $urandom_range(0, 1));
        end else begin
            send_bytes(q, 1'b1);
        end
    endtask

    task automatic random_part(input int goal);
        int start;
        start = chars_sent;
        while (chars_sent - start < goal) begin
            calm = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 5) == 0)
                send_char($urandom_range(0, 255), $urandom_range(0, 4) == 0);
            else
                random_expression();
        end
        // close any expression left open
        send_char(8'h20, 1'b1);
        calm = 1'b0;
    endtask

    initial begin
        string directed [24] = '{
            "-12.5pt", "+-3in", "-+4", "1/0", "7*2.25cm", "abc+3", "3\"x", "2'",
            "1.1234567mm", "5no", "4cb", "6pc", "2ft", "*", "-", "12 ", "x9/2",
            "32768/65535.999", "65535.99999*65535", "8/3-1.5", "Zq7+.5", "9in/2pt",
            "2ptxyz;", "1p+2"
        };
        in_ch.valid       <= 1'b0;
        in_ch.text_char   <= 8'h00;
        in_ch.end_of_text <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= 2'd0;
        calm       = 1'b0;
        chars_sent = 0;
        i_rst_n    = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_unit(2'd0);
        foreach (directed[i]) send_text(directed[i]);
        settle_idle();

        write_unit(DU_INCH);
        send_text("2.5");
        random_part(75);
        settle_idle();
        write_unit(DU_POINT);
        send_text("65535");
        random_part(75);
        settle_idle();
        write_unit(2'd3);
        random_part(55);
        settle_idle();
        write_unit(2'd0);
        random_part(95);
        settle_idle();

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
